// ===== rtl/mlcd_pkg.sv =====
// Shared types, constants and helpers for the memory LCD frame controller.
`timescale 1ns / 1ps
package mlcd_pkg;

    // panel geometry
    localparam int WIDTH       = 400;
    localparam int HEIGHT      = 240;
    localparam int DATA_BYTES  = WIDTH / 8;
    localparam int STORE_BYTES = DATA_BYTES * HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = ($clog2(DATA_BYTES) > 0) ? $clog2(DATA_BYTES) : 1;

    // input field widths
    localparam int X_W = 9;
    localparam int Y_W = 8;

    // command queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int FIFO_CW    = 2;

    // request codes on the input channel
    localparam logic [1:0] REQ_DRAW    = 2'd0;
    localparam logic [1:0] REQ_CLEAR   = 2'd1;
    localparam logic [1:0] REQ_REFRESH = 2'd2;

    // frame bytes
    localparam logic [7:0] CMD_VCOM_LO = 8'b1000_0000;
    localparam logic [7:0] CMD_VCOM_HI = 8'b1100_0000;
    localparam logic [7:0] FILL_WHITE  = 8'b1111_1111;
    localparam logic [7:0] TRAILER     = 8'b0000_0000;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [Y_W-1:0]    t_line;
    typedef logic [7:0]        t_byte;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_CLEAR,
        OP_REFRESH
    } t_op;

    typedef struct packed {
        t_op   op;
        t_addr addr;
        t_byte mask;
        logic  color;
    } t_cmd;

    typedef enum logic {
        BK_CLEAR,
        BK_RUN
    } t_bk_state;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_ADDR,
        PH_DATA,
        PH_TRAIL,
        PH_LAST
    } t_phase;

    function automatic t_byte f_rev8(input t_byte v);
        t_byte r;
        r = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        r = ((r & 8'hCC) >> 2) | ((r & 8'h33) << 2);
        r = ((r & 8'hAA) >> 1) | ((r & 8'h55) << 1);
        return r;
    endfunction

endpackage

// ===== rtl/mlcd_if.sv =====
// Valid/ready channel interfaces for requests and frame bytes.
`timescale 1ns / 1ps
interface mlcd_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [mlcd_pkg::X_W-1:0] x;
    logic [mlcd_pkg::Y_W-1:0] y;
    logic                     color;

    modport source (output valid, req_type, x, y, color, input ready);
    modport sink   (input valid, req_type, x, y, color, output ready);
endinterface

interface mlcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

// ===== rtl/mlcd_front.sv =====
// Request front end: accepts beats, drops no-op requests, builds store commands.
`timescale 1ns / 1ps
module mlcd_front (
    mlcd_in_if.sink          i_in,
    input  logic             i_fifo_full,
    input  logic             i_init_busy,
    output logic             o_push,
    output mlcd_pkg::t_cmd   o_cmd
);

    logic [5:0] x_byte;
    logic       on_screen;
    logic       keep;

    assign i_in.ready = !i_fifo_full && !i_init_busy;
    assign x_byte     = i_in.x[8:3];

    // columns of a partial last byte have no storage
    assign on_screen = (12'(i_in.x) < 12'(mlcd_pkg::WIDTH))
                    && (12'(i_in.y) < 12'(mlcd_pkg::HEIGHT))
                    && (12'(x_byte) < 12'(mlcd_pkg::DATA_BYTES));

    always_comb begin
        keep        = 1'b0;
        o_cmd.op    = mlcd_pkg::OP_DRAW;
        o_cmd.addr  = mlcd_pkg::t_addr'(i_in.y) * mlcd_pkg::t_addr'(mlcd_pkg::DATA_BYTES)
                    + mlcd_pkg::t_addr'(x_byte);
        o_cmd.mask  = 8'h80 >> i_in.x[2:0];
        o_cmd.color = i_in.color;
        case (i_in.req_type)
            mlcd_pkg::REQ_DRAW: begin
                keep = on_screen;
            end
            mlcd_pkg::REQ_CLEAR: begin
                keep     = 1'b1;
                o_cmd.op = mlcd_pkg::OP_CLEAR;
            end
            mlcd_pkg::REQ_REFRESH: begin
                keep     = 1'b1;
                o_cmd.op = mlcd_pkg::OP_REFRESH;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_in.valid && i_in.ready && keep;

endmodule

// ===== rtl/mlcd_cmd_fifo.sv =====
// Two-entry command queue between the front end and the store engine.
`timescale 1ns / 1ps
module mlcd_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mlcd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output mlcd_pkg::t_cmd o_head
);

    mlcd_pkg::t_cmd                     r_mem [mlcd_pkg::FIFO_DEPTH];
    logic [mlcd_pkg::FIFO_AW-1:0]       r_wptr;
    logic [mlcd_pkg::FIFO_AW-1:0]       r_rptr;
    logic [mlcd_pkg::FIFO_CW-1:0]       r_count;

    assign o_full  = (r_count == mlcd_pkg::FIFO_CW'(mlcd_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/mlcd_back.sv =====
// Store engine: pixel store, clear sweep, frame sequencer and output register.
`timescale 1ns / 1ps
module mlcd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fifo_empty,
    input  mlcd_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic           o_init_busy,
    mlcd_out_if.source     o_out
);

    logic [7:0] mem [mlcd_pkg::STORE_BYTES];

    mlcd_pkg::t_bk_state r_state, n_state;
    mlcd_pkg::t_phase    r_phase, n_phase;
    mlcd_pkg::t_addr     r_clr_addr, n_clr_addr;
    mlcd_pkg::t_addr     r_rd_addr, n_rd_addr;
    mlcd_pkg::t_line     r_line, n_line;
    mlcd_pkg::t_col      r_col, n_col;
    logic                r_init, n_init;
    logic                r_vcom_80, n_vcom_80;

    logic            pop_ref;
    logic            we;
    mlcd_pkg::t_addr waddr;
    mlcd_pkg::t_byte wmask;
    mlcd_pkg::t_byte wdata;
    logic            re;
    mlcd_pkg::t_byte r_rdata;

    logic            s1_byte_mem;
    mlcd_pkg::t_byte s1_byte;
    logic            s1_last;
    logic            r_s1_valid;
    logic            r_s1_mem;
    mlcd_pkg::t_byte r_s1_byte;
    logic            r_s1_last;
    logic            s1_move;
    logic            s1_free;

    logic            r_out_valid;
    mlcd_pkg::t_byte r_out_byte;
    logic            r_out_last;

    assign s1_move = !r_out_valid || o_out.ready;
    assign s1_free = !r_s1_valid || s1_move;

    // next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_init     = r_init;
        n_phase    = r_phase;
        n_rd_addr  = r_rd_addr;
        n_line     = r_line;
        n_col      = r_col;
        n_vcom_80  = r_vcom_80;
        case (r_state)
            mlcd_pkg::BK_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == mlcd_pkg::t_addr'(mlcd_pkg::STORE_BYTES - 1)) begin
                    n_state    = mlcd_pkg::BK_RUN;
                    n_init     = 1'b0;
                    n_clr_addr = '0;
                end
            end
            mlcd_pkg::BK_RUN: begin
                if (o_pop && i_head.op == mlcd_pkg::OP_CLEAR) begin
                    n_state = mlcd_pkg::BK_CLEAR;
                end
            end
            default: begin
                n_state = mlcd_pkg::BK_RUN;
            end
        endcase
        if (pop_ref) begin
            case (r_phase)
                mlcd_pkg::PH_CMD: begin
                    n_vcom_80 = !r_vcom_80;
                    n_line    = '0;
                    n_rd_addr = '0;
                    n_phase   = mlcd_pkg::PH_ADDR;
                end
                mlcd_pkg::PH_ADDR: begin
                    n_col   = '0;
                    n_phase = mlcd_pkg::PH_DATA;
                end
                mlcd_pkg::PH_DATA: begin
                    n_rd_addr = r_rd_addr + 1'b1;
                    n_col     = r_col + 1'b1;
                    if (r_col == mlcd_pkg::t_col'(mlcd_pkg::DATA_BYTES - 1)) begin
                        n_phase = mlcd_pkg::PH_TRAIL;
                    end
                end
                mlcd_pkg::PH_TRAIL: begin
                    if (r_line == mlcd_pkg::t_line'(mlcd_pkg::HEIGHT - 1)) begin
                        n_phase = mlcd_pkg::PH_LAST;
                    end else begin
                        n_line  = r_line + 1'b1;
                        n_phase = mlcd_pkg::PH_ADDR;
                    end
                end
                mlcd_pkg::PH_LAST: begin
                    n_phase = mlcd_pkg::PH_CMD;
                end
                default: begin
                    n_phase = mlcd_pkg::PH_CMD;
                end
            endcase
        end
    end

    // outputs: queue pop, store port controls, frame byte for stage 1
    always_comb begin
        o_pop       = 1'b0;
        we          = 1'b0;
        waddr       = r_clr_addr;
        wmask       = mlcd_pkg::FILL_WHITE;
        wdata       = mlcd_pkg::FILL_WHITE;
        re          = 1'b0;
        s1_byte     = mlcd_pkg::TRAILER;
        s1_last     = 1'b0;
        s1_byte_mem = 1'b0;
        case (r_state)
            mlcd_pkg::BK_CLEAR: begin
                we = 1'b1;
            end
            mlcd_pkg::BK_RUN: begin
                o_pop = !i_fifo_empty && (i_head.op != mlcd_pkg::OP_REFRESH || s1_free);
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
        if (o_pop && i_head.op == mlcd_pkg::OP_DRAW) begin
            we    = 1'b1;
            waddr = i_head.addr;
            wmask = i_head.mask;
            wdata = {8{i_head.color}};
        end
        pop_ref = o_pop && i_head.op == mlcd_pkg::OP_REFRESH;
        case (r_phase)
            mlcd_pkg::PH_CMD: begin
                s1_byte = r_vcom_80 ? mlcd_pkg::CMD_VCOM_HI : mlcd_pkg::CMD_VCOM_LO;
            end
            mlcd_pkg::PH_ADDR: begin
                s1_byte = mlcd_pkg::f_rev8(r_line + 1'b1);
            end
            mlcd_pkg::PH_DATA: begin
                s1_byte_mem = 1'b1;
                re          = pop_ref;
            end
            mlcd_pkg::PH_TRAIL: begin
                s1_byte = mlcd_pkg::TRAILER;
            end
            mlcd_pkg::PH_LAST: begin
                s1_byte = mlcd_pkg::TRAILER;
                s1_last = 1'b1;
            end
            default: begin
                s1_byte = mlcd_pkg::TRAILER;
            end
        endcase
    end

    // pixel store with per-bit write enables
    always_ff @(posedge i_clk) begin
        if (we) begin
            for (int b = 0; b < 8; b++) begin
                if (wmask[b]) begin
                    mem[waddr][b] <= wdata[b];
                end
            end
        end
        if (re) begin
            r_rdata <= mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlcd_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_init      <= 1'b1;
            r_phase     <= mlcd_pkg::PH_CMD;
            r_rd_addr   <= '0;
            r_line      <= '0;
            r_col       <= '0;
            r_vcom_80   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_init      <= n_init;
            r_phase     <= n_phase;
            r_rd_addr   <= n_rd_addr;
            r_line      <= n_line;
            r_col       <= n_col;
            r_vcom_80   <= n_vcom_80;
            r_s1_valid  <= pop_ref || (r_s1_valid && !s1_move);
            r_out_valid <= (r_s1_valid && s1_move) || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_ref) begin
            r_s1_mem  <= s1_byte_mem;
            r_s1_byte <= s1_byte;
            r_s1_last <= s1_last;
        end
        if (r_s1_valid && s1_move) begin
            r_out_byte <= r_s1_mem ? r_rdata : r_s1_byte;
            r_out_last <= r_s1_last;
        end
    end

    assign o_init_busy      = r_init;
    assign o_out.valid      = r_out_valid;
    assign o_out.frame_byte = r_out_byte;
    assign o_out.last_byte  = r_out_last;

`ifndef SYNTH
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlcd_pkg::BK_CLEAR) |-> !o_pop)
        else $error("command popped during clear sweep");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1_byte)))
        else $error("stage 1 lost a stalled byte");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ref && r_phase == mlcd_pkg::PH_LAST) |=> (r_phase == mlcd_pkg::PH_CMD))
        else $error("frame did not restart after last byte");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        re |-> (r_rd_addr < mlcd_pkg::t_addr'(mlcd_pkg::STORE_BYTES)))
        else $error("store read beyond frame data");

    a_last_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_byte == mlcd_pkg::TRAILER))
        else $error("last byte is not a zero trailer");
`endif

endmodule

// ===== rtl/memory_lcd_frame_controller_core.sv =====
// Top level of the memory LCD frame controller.
`timescale 1ns / 1ps
// Memory LCD frame controller.
// i_in carries requests: draw pixel (x, y, color), clear the framebuffer, or
// emit the next refresh byte. o_out carries one beat per refresh request: the
// frame byte and a flag on the final zero byte of the frame. Draws and clears
// produce no beat; off-screen draws and unknown request codes are dropped.
// Requests enter a two-entry command queue; the store engine drains it in order.
// Throughput: one request per cycle for draws and refresh bytes while o_out.ready
// is high and no clear is running. A clear occupies the store engine while it
// sweeps every store byte (one byte per cycle through the single store write
// port); requests queue behind it and i_in.ready drops once the queue is full.
// A refresh beat passes the queue, the store read with the stage 1 register,
// and then the output register before it is valid on o_out.
// Reset: synchronous, active low. After reset every store byte is swept to
// white, and i_in.ready stays low until the sweep is done.
// A stalled o_out.ready holds the output register and one byte behind it;
// the next refresh request waits at the queue head and everything behind it
// waits too, so i_in.ready drops once the queue is full.
module memory_lcd_frame_controller_core (
    input logic         i_clk,
    input logic         i_rst_n,
    mlcd_in_if.sink     i_in,
    mlcd_out_if.source  o_out
);

    logic           push;
    logic           pop;
    logic           fifo_full;
    logic           fifo_empty;
    logic           init_busy;
    mlcd_pkg::t_cmd cmd_in;
    mlcd_pkg::t_cmd cmd_head;

    mlcd_front u_front (
        .i_in        (i_in),
        .i_fifo_full (fifo_full),
        .i_init_busy (init_busy),
        .o_push      (push),
        .o_cmd       (cmd_in)
    );

    mlcd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_head  (cmd_head)
    );

    mlcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (fifo_empty),
        .i_head       (cmd_head),
        .o_pop        (pop),
        .o_init_busy  (init_busy),
        .o_out        (o_out)
    );

endmodule
